FILE: rtl/pecdf_pkg.sv
// shared types and constants for the piecewise exponential cdf block
package pecdf_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam logic [30:0] EXP_M1 = 31'd1580030169;
  localparam logic [3:0]  TERMS  = 4'd14;
  localparam logic [5:0]  DIVBITS = 6'd33;

  typedef struct packed {
    logic        last;
    logic        first_below;
    logic [31:0] len_a;
    logic [31:0] rate_a;
    logic [31:0] len_b;
    logic [31:0] rate_b;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MA, S_AA, S_MB, S_AB, S_EX0, S_TM, S_DV, S_UPD, S_KM, S_FIN
  } state_t;

endpackage

FILE: rtl/pecdf_front.sv
// front end: holds the open interval and turns items into hazard terms
module pecdf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [31:0]         q,
  input  logic [31:0]         c,
  input  logic [31:0]         r,
  input  logic                last,
  output pecdf_pkg::entry_t   ent
);

  logic [31:0] pst_r, pst_nxt;
  logic [31:0] prt_r, prt_nxt;
  logic        pv_r, pv_nxt;
  logic        fb_r, fb_nxt;
  logic [31:0] endt;

  always_comb begin
    endt = (q < c) ? q : c;
    ent.last        = last;
    ent.first_below = pv_r ? fb_r : (q < c);
    ent.len_a       = (pv_r && endt > pst_r) ? endt - pst_r : 32'd0;
    ent.rate_a      = prt_r;
    ent.len_b       = (last && q > c) ? q - c : 32'd0;
    ent.rate_b      = r;
    pst_nxt = pst_r;
    prt_nxt = prt_r;
    pv_nxt  = pv_r;
    fb_nxt  = fb_r;
    if (acc) begin
      if (last) begin
        pst_nxt = 32'd0;
        prt_nxt = 32'd0;
        pv_nxt  = 1'b0;
        fb_nxt  = 1'b0;
      end else begin
        pst_nxt = c;
        prt_nxt = r;
        pv_nxt  = 1'b1;
        fb_nxt  = ent.first_below;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pst_r <= 32'd0;
      prt_r <= 32'd0;
      pv_r  <= 1'b0;
      fb_r  <= 1'b0;
    end else begin
      pst_r <= pst_nxt;
      prt_r <= prt_nxt;
      pv_r  <= pv_nxt;
      fb_r  <= fb_nxt;
    end
  end

endmodule

FILE: rtl/pecdf_queue.sv
// short queue of hazard terms between front and back
module pecdf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  pecdf_pkg::entry_t wdata,
  input  logic              rd,
  output pecdf_pkg::entry_t rdata,
  output logic              full,
  output logic              empty
);

  pecdf_pkg::entry_t mem [pecdf_pkg::QDEPTH];
  logic [pecdf_pkg::QPTRW-1:0] wp_r, rp_r;
  logic [pecdf_pkg::QPTRW:0]   cnt_r;

  assign full  = (cnt_r == (pecdf_pkg::QPTRW+1)'(pecdf_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      if (wr && !rd) cnt_r <= cnt_r + 1'b1;
      else if (rd && !wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: rtl/pecdf_back.sv
// back end: hazard accumulation, exp evaluation and result register
module pecdf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  pecdf_pkg::entry_t q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [15:0]       cdf_value,
  output logic              below_first_cut,
  output logic              hazard_saturated
);

  pecdf_pkg::state_t st_r, st_nxt;
  pecdf_pkg::entry_t ent_r, ent_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] hsum_r, hsum_nxt;
  logic        ovf_r, ovf_nxt;
  logic [32:0] term_r, term_nxt;
  logic [32:0] sum_r, sum_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [31:0] f_r, f_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [4:0]  rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] e_r, e_nxt;
  logic        ov_r, ov_nxt;
  logic [15:0] ocdf_r, ocdf_nxt;
  logic        ofb_r, ofb_nxt;
  logic        osat_r, osat_nxt;
  logic [64:0] acc_sum;
  logic [64:0] mt;
  logic [63:0] km;
  logic [4:0]  rem_t;
  logic [33:0] fin;
  logic        out_free;

  assign out_free = !ov_r || pop;
  assign acc_sum  = {1'b0, hsum_r} + {1'b0, prod_r};
  assign mt       = {32'd0, term_r} * {33'd0, f_r};
  assign km       = {31'd0, e_r} * {33'd0, pecdf_pkg::EXP_M1} + 64'h8000_0000;
  assign rem_t    = {rem_r[3:0], quo_r[32]};
  assign fin      = 34'h1_0000_0000 - {1'b0, e_r} + 34'h8000;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pecdf_pkg::S_IDLE: if (!q_empty) st_nxt = pecdf_pkg::S_MA;
      pecdf_pkg::S_MA:   st_nxt = pecdf_pkg::S_AA;
      pecdf_pkg::S_AA: begin
        if (ent_r.last) st_nxt = pecdf_pkg::S_MB;
        else if (!q_empty) st_nxt = pecdf_pkg::S_MA;
        else st_nxt = pecdf_pkg::S_IDLE;
      end
      pecdf_pkg::S_MB:   st_nxt = pecdf_pkg::S_AB;
      pecdf_pkg::S_AB:   st_nxt = pecdf_pkg::S_EX0;
      pecdf_pkg::S_EX0: begin
        if (ent_r.first_below || ovf_r || hsum_r[63:36] != '0) st_nxt = pecdf_pkg::S_FIN;
        else st_nxt = pecdf_pkg::S_TM;
      end
      pecdf_pkg::S_TM:   st_nxt = pecdf_pkg::S_DV;
      pecdf_pkg::S_DV:   if (cnt_r == 6'd1) st_nxt = pecdf_pkg::S_UPD;
      pecdf_pkg::S_UPD:  st_nxt = (n_r == pecdf_pkg::TERMS) ? pecdf_pkg::S_KM : pecdf_pkg::S_TM;
      pecdf_pkg::S_KM:   if (k_r == 4'd0) st_nxt = pecdf_pkg::S_FIN;
      pecdf_pkg::S_FIN:  if (out_free) st_nxt = pecdf_pkg::S_IDLE;
      default:           st_nxt = pecdf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    ent_nxt  = ent_r;
    prod_nxt = prod_r;
    hsum_nxt = hsum_r;
    ovf_nxt  = ovf_r;
    term_nxt = term_r;
    sum_nxt  = sum_r;
    n_nxt    = n_r;
    k_nxt    = k_r;
    f_nxt    = f_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    e_nxt    = e_r;
    ov_nxt   = ov_r && !pop;
    ocdf_nxt = ocdf_r;
    ofb_nxt  = ofb_r;
    osat_nxt = osat_r;
    unique case (st_r)
      pecdf_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_data;
        end
      end
      pecdf_pkg::S_MA: prod_nxt = {32'd0, ent_r.rate_a} * {32'd0, ent_r.len_a};
      pecdf_pkg::S_AA, pecdf_pkg::S_AB: begin
        if (acc_sum[64]) begin
          hsum_nxt = '1;
          ovf_nxt  = 1'b1;
        end else begin
          hsum_nxt = acc_sum[63:0];
        end
        if (st_r == pecdf_pkg::S_AA && !ent_r.last && !q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_data;
        end
      end
      pecdf_pkg::S_MB: prod_nxt = {32'd0, ent_r.rate_b} * {32'd0, ent_r.len_b};
      pecdf_pkg::S_EX0: begin
        k_nxt    = hsum_r[35:32];
        f_nxt    = hsum_r[31:0];
        term_nxt = 33'h1_0000_0000;
        sum_nxt  = 33'h1_0000_0000;
        n_nxt    = 4'd1;
        e_nxt    = '0;
      end
      pecdf_pkg::S_TM: begin
        quo_nxt = mt[64:32];
        rem_nxt = '0;
        cnt_nxt = pecdf_pkg::DIVBITS;
      end
      pecdf_pkg::S_DV: begin
        if (rem_t >= {1'b0, n_r}) begin
          rem_nxt = rem_t - {1'b0, n_r};
          quo_nxt = {quo_r[31:0], 1'b1};
        end else begin
          rem_nxt = rem_t;
          quo_nxt = {quo_r[31:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
      end
      pecdf_pkg::S_UPD: begin
        term_nxt = quo_r;
        if (n_r[0]) sum_nxt = sum_r - quo_r;
        else sum_nxt = sum_r + quo_r;
        n_nxt = n_r + 1'b1;
        if (n_r == pecdf_pkg::TERMS) e_nxt = n_r[0] ? sum_r - quo_r : sum_r + quo_r;
      end
      pecdf_pkg::S_KM: begin
        if (k_r != 4'd0) begin
          e_nxt = km[63:31] >> 1;
          k_nxt = k_r - 1'b1;
        end
      end
      pecdf_pkg::S_FIN: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          ofb_nxt  = ent_r.first_below;
          osat_nxt = ovf_r;
          if (ent_r.first_below) ocdf_nxt = 16'd0;
          else if (ovf_r || fin[33:32] != 2'b00) ocdf_nxt = 16'hffff;
          else ocdf_nxt = fin[31:16];
          hsum_nxt = '0;
          ovf_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= pecdf_pkg::S_IDLE;
      hsum_r <= '0;
      ovf_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      hsum_r <= hsum_nxt;
      ovf_r  <= ovf_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    prod_r <= prod_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    f_r    <= f_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    e_r    <= e_nxt;
    ocdf_r <= ocdf_nxt;
    ofb_r  <= ofb_nxt;
    osat_r <= osat_nxt;
  end

  assign empty            = !ov_r;
  assign cdf_value        = ocdf_r;
  assign below_first_cut  = ofb_r;
  assign hazard_saturated = osat_r;

endmodule

FILE: rtl/piecewise_exponential_cdf_top.sv
// top level of the piecewise exponential cdf block
// interval items: each passes through the shared multiply and saturating add, and the next is taken during the add
// last item: the exp of the hazard (integer part k, up to 15) is built from 14 taylor terms of its fraction,
// each with a 33-bit bit-serial divide, then scaled by exp(-1) for each unit of k; a 4-entry queue decouples the front
// synchronous active-low reset empties the queue and clears all run state
module piecewise_exponential_cdf_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_query_time,
  input  logic [31:0] in_cut_time,
  input  logic [31:0] in_hazard_rate,
  input  logic        in_last_interval,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_cdf_value,
  output logic        out_below_first_cut,
  output logic        out_hazard_saturated
);

  pecdf_pkg::entry_t fe_ent, q_data;
  logic q_full, q_empty, q_pop, acc;

  assign full = q_full;
  assign acc  = push && !q_full;

  pecdf_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc),
    .q(in_query_time), .c(in_cut_time), .r(in_hazard_rate), .last(in_last_interval),
    .ent(fe_ent)
  );

  pecdf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr(acc), .wdata(fe_ent), .rd(q_pop),
    .rdata(q_data), .full(q_full), .empty(q_empty)
  );

  pecdf_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .pop(pop), .empty(empty), .cdf_value(out_cdf_value),
    .below_first_cut(out_below_first_cut), .hazard_saturated(out_hazard_saturated)
  );

endmodule

FILE: sim/piecewise_exponential_cdf_checker.sv
// scoreboard for the piecewise exponential cdf block: run predictor and result compare
module piecewise_exponential_cdf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [31:0] in_query_time,
  input  logic [31:0] in_cut_time,
  input  logic [31:0] in_hazard_rate,
  input  logic        in_last_interval,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] out_cdf_value,
  input  logic        out_below_first_cut,
  input  logic        out_hazard_saturated,
  output int          failures,
  output int          outstanding,
  output int          checked,
  output int          below_seen,
  output int          sat_seen
);

  typedef struct packed {
    logic [15:0] cdf;
    logic        below;
    logic        sat;
  } cdf_result_t;

  cdf_result_t cdf_queue[$];

  logic [31:0] held_start;
  logic [31:0] held_rate;
  logic        held_valid;
  logic [63:0] hazard_acc;
  logic        hazard_ovf;
  logic        query_below;

  function automatic logic [63:0] exp_neg_q32(input logic [63:0] h);
    logic [63:0] k;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] n;
    k = h >> 32;
    f = {32'd0, h[31:0]};
    if (k >= 64'd16) return 64'd0;
    term = 64'h1_0000_0000;
    acc  = term;
    for (n = 64'd1; n <= 64'd14; n++) begin
      term = ((term * f) >> 32) / n;
      if (n[0]) acc = acc - term;
      else acc = acc + term;
    end
    while (k > 0) begin
      acc = (acc * 64'd1580030169 + 64'h8000_0000) >> 32;
      k = k - 1;
    end
    return acc;
  endfunction

  task automatic add_hazard(input logic [31:0] rate, input logic [31:0] len);
    logic [63:0] prod;
    logic [64:0] total;
    prod  = {32'd0, rate} * {32'd0, len};
    total = {1'b0, hazard_acc} + {1'b0, prod};
    if (total[64]) begin
      hazard_acc = '1;
      hazard_ovf = 1'b1;
    end else begin
      hazard_acc = total[63:0];
    end
  endtask

  task automatic clear_run();
    held_start  = '0;
    held_rate   = '0;
    held_valid  = 1'b0;
    hazard_acc  = '0;
    hazard_ovf  = 1'b0;
    query_below = 1'b0;
  endtask

  task automatic predict_item(input logic [31:0] q, input logic [31:0] c,
                              input logic [31:0] r, input logic last);
    logic [31:0] stop;
    logic [63:0] e;
    logic [63:0] v;
    cdf_result_t res;
    if (!held_valid) begin
      query_below = q < c;
    end else begin
      stop = (q < c) ? q : c;
      if (stop > held_start) add_hazard(held_rate, stop - held_start);
    end
    if (!last) begin
      held_start = c;
      held_rate  = r;
      held_valid = 1'b1;
    end else begin
      if (q > c) add_hazard(r, q - c);
      if (query_below) v = 64'd0;
      else if (hazard_ovf) v = 64'd65535;
      else begin
        e = exp_neg_q32(hazard_acc);
        v = (64'h1_0000_0000 - e + 64'h8000) >> 16;
        if (v > 64'd65535) v = 64'd65535;
      end
      res.cdf   = v[15:0];
      res.below = query_below;
      res.sat   = hazard_ovf;
      cdf_queue.push_back(res);
      clear_run();
    end
  endtask

  initial begin
    failures = 0;
    checked = 0;
    below_seen = 0;
    sat_seen = 0;
    clear_run();
  end

  assign outstanding = cdf_queue.size();

  always @(posedge clk) begin
    cdf_result_t want;
    if (!rst_n) begin
      clear_run();
      cdf_queue.delete();
    end else begin
      if (pop && !empty) begin
        if (cdf_queue.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: cdf=%0d below=%0b sat=%0b", out_cdf_value,
                     out_below_first_cut, out_hazard_saturated);
        end else begin
          want = cdf_queue.pop_front();
          checked++;
          if (want.below) below_seen++;
          if (want.sat) sat_seen++;
          if (want.cdf !== out_cdf_value || want.below !== out_below_first_cut ||
              want.sat !== out_hazard_saturated) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: expected cdf=%0d below=%0b sat=%0b, got cdf=%0d below=%0b sat=%0b",
                       want.cdf, want.below, want.sat, out_cdf_value,
                       out_below_first_cut, out_hazard_saturated);
          end
        end
      end
      if (push && !full)
        predict_item(in_query_time, in_cut_time, in_hazard_rate, in_last_interval);
    end
  end

endmodule

FILE: sim/piecewise_exponential_cdf_top_tb.sv
// testbench top for the piecewise exponential cdf block: stimulus and verdict
module piecewise_exponential_cdf_top_tb;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [31:0] in_query_time;
  logic [31:0] in_cut_time;
  logic [31:0] in_hazard_rate;
  logic        in_last_interval;
  logic        empty;
  logic        pop;
  logic [15:0] out_cdf_value;
  logic        out_below_first_cut;
  logic        out_hazard_saturated;

  int failures;
  int outstanding;
  int checked;
  int below_seen;
  int sat_seen;
  int sent;
  int runs;
  int send_idle;
  int recv_idle;
  int cycles;

  piecewise_exponential_cdf_top dut (.*);

  piecewise_exponential_cdf_checker chk (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    push = 1'b0;
    in_query_time = '0;
    in_cut_time = '0;
    in_hazard_rate = '0;
    in_last_interval = 1'b0;
    pop = 1'b0;
    rst_n = 1'b0;
    sent = 0;
    runs = 0;
    send_idle = 28;
    recv_idle = 74;
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("piecewise_exponential_cdf_top_tb: FAIL");
      $finish;
    end
  end

  // receiver with one long hold-off so the queue fills and stalls the sender
  initial begin
    int hold;
    bit held;
    held = 0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sent >= 60) begin
        held = 1;
        hold = 1500;
      end
      if (hold > 0) begin
        hold--;
        pop = 1'b0;
      end else begin
        pop = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_item(input logic [31:0] q, input logic [31:0] c,
                           input logic [31:0] r, input logic last);
    while ($urandom_range(99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_query_time = q;
    in_cut_time = c;
    in_hazard_rate = r;
    in_last_interval = last;
    forever begin
      if (!full) begin
        @(posedge clk);
        break;
      end
      @(negedge clk);
    end
    @(negedge clk);
    push = 1'b0;
    sent++;
    if (last) runs++;
    if (sent == 150) begin
      send_idle = 74;
      recv_idle = 28;
    end else if (sent == 300) begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h4_0000);
    endcase
  endfunction

  task automatic random_run();
    int n;
    int i;
    logic [31:0] c;
    logic [31:0] q;
    logic [31:0] top;
    logic vary;
    n = $urandom_range(1, 5);
    vary = ($urandom_range(9) == 0);
    c = $urandom_range(32'h10_0000);
    top = c;
    for (i = 1; i < n; i++) top = top + $urandom_range(32'h4_0000);
    q = ($urandom_range(9) == 0) ? $urandom_range(c) : c + $urandom_range(top - c + 32'h4_0000);
    for (i = 0; i < n; i++) begin
      if (vary) q = c + $urandom_range(32'h8_0000);
      if ($urandom_range(19) == 0)
        send_item($urandom, $urandom, $urandom, i == n - 1);
      else
        send_item(q, c, pick_rate(), i == n - 1);
      c = c + $urandom_range(32'h4_0000);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // single item runs at the field extremes
    send_item(32'h0, 32'h0, 32'h0, 1'b1);
    send_item(32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(32'h0001_0000, 32'h0, 32'h0000_8000, 1'b1);
    // query before first cut
    send_item(32'h0000_1000, 32'h0002_0000, 32'h0001_0000, 1'b0);
    send_item(32'h0000_1000, 32'h0003_0000, 32'h0001_0000, 1'b1);
    // large hazard over two near-max intervals, just short of overflow
    send_item(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
    // cuts not ascending
    send_item(32'h0005_0000, 32'h0003_0000, 32'h0001_0000, 1'b0);
    send_item(32'h0005_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
    send_item(32'h0005_0000, 32'h0004_0000, 32'h0000_4000, 1'b1);
    // query varying within a run
    send_item(32'h0002_0000, 32'h0, 32'h0001_0000, 1'b0);
    send_item(32'h0000_8000, 32'h0001_0000, 32'h0003_0000, 1'b0);
    send_item(32'h0009_0000, 32'h0002_0000, 32'h0000_2000, 1'b1);
    // large hazard, integer part beyond the exp range and at its top
    send_item(32'h0014_0000, 32'h0, 32'h0001_0000, 1'b1);
    send_item(32'h000F_8000, 32'h0, 32'h0001_0000, 1'b1);
    // tiny hazard
    send_item(32'h0000_0001, 32'h0, 32'h0000_0001, 1'b1);
    while (sent < 280) random_run();
    while (outstanding != 0) @(negedge clk);
    while (sent < 450) random_run();
    while (outstanding != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    $display("sent %0d items in %0d runs, checked %0d results", sent, runs, checked);
    $display("below first cut %0d, hazard saturated %0d", below_seen, sat_seen);
    if (failures == 0 && outstanding == 0) begin
      $display("piecewise_exponential_cdf_top_tb: PASS");
    end else begin
      $display("piecewise_exponential_cdf_top_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pecdf_pkg.sv
rtl/pecdf_front.sv
rtl/pecdf_queue.sv
rtl/pecdf_back.sv
rtl/piecewise_exponential_cdf_top.sv
sim/piecewise_exponential_cdf_checker.sv
sim/piecewise_exponential_cdf_top_tb.sv
